// ----- hdl/token_lexer_defines.svh -----
// Assertion macros shared by the token_lexer checker.
// No dependencies; the user supplies clk_i and rst_ni in scope.
`ifndef TOKEN_LEXER_DEFINES_SVH
`define TOKEN_LEXER_DEFINES_SVH

// Checked at every clock edge outside reset.
`define TLEX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same check with a named clock and reset.
`define TLEX_ASSERT_CR(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

// ----- hdl/tlex_pkg.sv -----
// Package for the token lexer: token kinds, scanner modes, character
// constants, the state and request structs and the byte classifiers.
// No dependencies.
package tlex_pkg;

  localparam int unsigned LINE_W = 20;
  localparam int unsigned COL_W  = 16;
  localparam int unsigned OFF_W  = 32;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned HEAD_W = 32;

  typedef enum logic [4:0] {
    KIND_EOF    = 5'd0,
    KIND_ADD    = 5'd1,
    KIND_SUB    = 5'd2,
    KIND_MUL    = 5'd3,
    KIND_DIV    = 5'd4,
    KIND_ASSIGN = 5'd5,
    KIND_EQ     = 5'd6,
    KIND_LT     = 5'd7,
    KIND_GT     = 5'd8,
    KIND_LPAREN = 5'd9,
    KIND_RPAREN = 5'd10,
    KIND_LBRACE = 5'd11,
    KIND_RBRACE = 5'd12,
    KIND_COMMA  = 5'd13,
    KIND_SEMI   = 5'd14,
    KIND_NUMBER = 5'd15,
    KIND_IDENT  = 5'd16,
    KIND_DEF    = 5'd17,
    KIND_VAL    = 5'd18,
    KIND_IF     = 5'd19,
    KIND_ELSE   = 5'd20,
    KIND_ERROR  = 5'd21
  } tok_kind_e;

  typedef enum logic [6:0] {
    MODE_IDLE    = 7'b0000001,
    MODE_NUM     = 7'b0000010,
    MODE_IDENT   = 7'b0000100,
    MODE_SLASH   = 7'b0001000,
    MODE_EQ      = 7'b0010000,
    MODE_COMMENT = 7'b0100000,
    MODE_HALT    = 7'b1000000
  } lex_mode_e;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  localparam logic [HEAD_W-1:0] KW_DEF  = 32'h0066_6564;
  localparam logic [HEAD_W-1:0] KW_VAL  = 32'h006C_6176;
  localparam logic [HEAD_W-1:0] KW_IF   = 32'h0000_6669;
  localparam logic [HEAD_W-1:0] KW_ELSE = 32'h6573_6C65;

  typedef struct packed {
    lex_mode_e         mode;
    logic [LINE_W-1:0] cur_line;
    logic [COL_W-1:0]  cur_col;
    logic [OFF_W-1:0]  cur_off;
    logic [LINE_W-1:0] tok_line;
    logic [COL_W-1:0]  tok_col;
    logic [OFF_W-1:0]  tok_off;
    logic [LEN_W-1:0]  tok_len;
    logic [HEAD_W-1:0] head;
  } lex_state_t;

  typedef struct packed {
    tok_kind_e         kind;
    logic [LINE_W-1:0] bline;
    logic [COL_W-1:0]  bcol;
    logic [LINE_W-1:0] eline;
    logic [COL_W-1:0]  ecol;
    logic [OFF_W-1:0]  off;
    logic [LEN_W-1:0]  len;
    logic              last;
  } tok_res_t;

  function automatic logic [LINE_W-1:0] inc_line(input logic [LINE_W-1:0] v);
    return (&v) ? v : v + LINE_W'(1);
  endfunction

  function automatic logic [COL_W-1:0] inc_col(input logic [COL_W-1:0] v);
    return (&v) ? v : v + COL_W'(1);
  endfunction

  function automatic logic [OFF_W-1:0] inc_off(input logic [OFF_W-1:0] v);
    return (&v) ? v : v + OFF_W'(1);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  // KIND_EOF means the byte is no single-character operator
  function automatic tok_kind_e single_kind(input logic [7:0] b);
    tok_kind_e k;
    unique case (b)
      8'h2B:   k = KIND_ADD;
      8'h2D:   k = KIND_SUB;
      8'h2A:   k = KIND_MUL;
      8'h3C:   k = KIND_LT;
      8'h3E:   k = KIND_GT;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      8'h2C:   k = KIND_COMMA;
      8'h3B:   k = KIND_SEMI;
      default: k = KIND_EOF;
    endcase
    return k;
  endfunction

  function automatic tok_kind_e ident_kind(input logic [LEN_W-1:0] len,
                                           input logic [HEAD_W-1:0] head);
    tok_kind_e k;
    priority if (len == LEN_W'(3) && head == KW_DEF) k = KIND_DEF;
    else if (len == LEN_W'(3) && head == KW_VAL)     k = KIND_VAL;
    else if (len == LEN_W'(2) && head == KW_IF)      k = KIND_IF;
    else if (len == LEN_W'(4) && head == KW_ELSE)    k = KIND_ELSE;
    else                                             k = KIND_IDENT;
    return k;
  endfunction

endpackage

// ----- hdl/tlex_scan.sv -----
// Next-state and token logic of the lexer for one source byte.
// Purely combinational; depends on tlex_pkg.
module tlex_scan import tlex_pkg::*; (
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  input  lex_state_t st_i,
  output lex_state_t st_o,
  output tok_res_t   res0_o,
  output tok_res_t   res1_o,
  output logic [1:0] res_cnt_o
);

  logic [7:0]        b;
  logic              fin;
  logic              nl;
  logic [LINE_W-1:0] p_line;
  logic [COL_W-1:0]  p_col;
  logic [OFF_W-1:0]  p_off;
  logic [LEN_W-1:0]  g_len;
  logic [HEAD_W-1:0] g_head;
  tok_kind_e         sk;
  lex_state_t        i_st;
  tok_res_t          i_tok;
  logic              i_emit;
  tok_res_t          e_tok;
  logic              ended;

  always_comb begin
    b      = text_byte_i;
    fin    = end_of_text_i || (b == CH_NUL);
    nl     = (b == CH_LF);
    p_line = nl ? inc_line(st_i.cur_line) : st_i.cur_line;
    p_col  = nl ? '0 : inc_col(st_i.cur_col);
    p_off  = inc_off(st_i.cur_off);
    g_len  = (&st_i.tok_len) ? st_i.tok_len : st_i.tok_len + LEN_W'(1);
    g_head = st_i.head;
    if (st_i.tok_len < LEN_W'(4)) begin
      unique case (st_i.tok_len[1:0])
        2'd0: g_head[7:0]   = b;
        2'd1: g_head[15:8]  = b;
        2'd2: g_head[23:16] = b;
        2'd3: g_head[31:24] = b;
      endcase
    end
    sk = single_kind(b);

    // byte scanned with no token pending
    i_st       = st_i;
    i_st.mode  = MODE_IDLE;
    i_emit     = 1'b0;
    i_tok.kind  = KIND_EOF;
    i_tok.bline = st_i.cur_line;
    i_tok.bcol  = st_i.cur_col;
    i_tok.eline = st_i.cur_line;
    i_tok.ecol  = st_i.cur_col;
    i_tok.off   = st_i.cur_off;
    i_tok.len   = '0;
    i_tok.last  = 1'b1;
    if (fin) begin
      i_emit    = 1'b1;
      i_st.mode = MODE_HALT;
    end else if (is_space(b)) begin
      i_st.cur_line = p_line;
      i_st.cur_col  = p_col;
      i_st.cur_off  = p_off;
    end else begin
      i_st.tok_line = st_i.cur_line;
      i_st.tok_col  = st_i.cur_col;
      i_st.tok_off  = st_i.cur_off;
      i_st.tok_len  = LEN_W'(1);
      i_st.head     = {24'h0, b};
      i_st.cur_line = p_line;
      i_st.cur_col  = p_col;
      i_st.cur_off  = p_off;
      priority if (sk != KIND_EOF) begin
        i_emit      = 1'b1;
        i_tok.kind  = sk;
        i_tok.eline = p_line;
        i_tok.ecol  = p_col;
        i_tok.len   = LEN_W'(1);
      end else if (b == CH_SLASH) begin
        i_st.mode = MODE_SLASH;
      end else if (b == CH_EQ) begin
        i_st.mode = MODE_EQ;
      end else if (is_digit(b)) begin
        i_st.mode = MODE_NUM;
      end else if (is_alpha(b)) begin
        i_st.mode = MODE_IDENT;
      end else begin
        // unknown byte: not consumed
        i_st          = st_i;
        i_st.mode     = MODE_HALT;
        i_emit        = 1'b1;
        i_tok.kind    = KIND_ERROR;
      end
    end

    // pending token closed by this byte
    e_tok.kind  = KIND_NUMBER;
    e_tok.bline = st_i.tok_line;
    e_tok.bcol  = st_i.tok_col;
    e_tok.eline = st_i.cur_line;
    e_tok.ecol  = st_i.cur_col;
    e_tok.off   = st_i.tok_off;
    e_tok.len   = st_i.tok_len;
    e_tok.last  = 1'b0;

    ended     = 1'b0;
    st_o      = st_i;
    res0_o    = i_tok;
    res1_o    = i_tok;
    res_cnt_o = 2'd0;

    unique case (st_i.mode)
      MODE_IDLE: begin
        st_o      = i_st;
        res_cnt_o = {1'b0, i_emit};
      end
      MODE_NUM: begin
        if (!fin && is_digit(b)) begin
          st_o.tok_len  = g_len;
          st_o.head     = g_head;
          st_o.cur_line = p_line;
          st_o.cur_col  = p_col;
          st_o.cur_off  = p_off;
        end else begin
          ended      = 1'b1;
          e_tok.kind = KIND_NUMBER;
        end
      end
      MODE_IDENT: begin
        if (!fin && (is_alpha(b) || is_digit(b))) begin
          st_o.tok_len  = g_len;
          st_o.head     = g_head;
          st_o.cur_line = p_line;
          st_o.cur_col  = p_col;
          st_o.cur_off  = p_off;
        end else begin
          ended      = 1'b1;
          e_tok.kind = ident_kind(st_i.tok_len, st_i.head);
        end
      end
      MODE_SLASH: begin
        if (!fin && b == CH_SLASH) begin
          st_o.mode     = MODE_COMMENT;
          st_o.cur_line = p_line;
          st_o.cur_col  = p_col;
          st_o.cur_off  = p_off;
        end else begin
          ended      = 1'b1;
          e_tok.kind = KIND_DIV;
        end
      end
      MODE_EQ: begin
        if (!fin && b == CH_EQ) begin
          st_o.mode     = MODE_IDLE;
          st_o.tok_len  = g_len;
          st_o.head     = g_head;
          st_o.cur_line = p_line;
          st_o.cur_col  = p_col;
          st_o.cur_off  = p_off;
          res0_o        = e_tok;
          res0_o.kind   = KIND_EQ;
          res0_o.eline  = p_line;
          res0_o.ecol   = p_col;
          res0_o.len    = g_len;
          res_cnt_o     = 2'd1;
        end else begin
          ended      = 1'b1;
          e_tok.kind = KIND_ASSIGN;
        end
      end
      MODE_COMMENT: begin
        if (fin) begin
          st_o      = i_st;
          res_cnt_o = {1'b0, i_emit};
        end else begin
          st_o.cur_line = p_line;
          st_o.cur_col  = p_col;
          st_o.cur_off  = p_off;
          if (nl) st_o.mode = MODE_IDLE;
        end
      end
      MODE_HALT: begin
        st_o = st_i;
      end
      default: begin
        st_o = st_i;
      end
    endcase

    if (ended) begin
      st_o      = i_st;
      res0_o    = e_tok;
      res1_o    = i_tok;
      res_cnt_o = 2'd1 + {1'b0, i_emit};
    end
    res0_o.last = (res_cnt_o == 2'd1);
    res1_o.last = 1'b1;
  end

endmodule

// ----- hdl/token_lexer.sv -----
// Streaming lexical scanner: one source byte in, zero to two tokens out.
// Channels: input request (text_byte_i, end_of_text_i) on in_valid_i /
//   in_ready_o; token request on out_valid_o / out_ready_i. A request
//   moves on an edge where valid and ready are both high.
// Throughput: one byte per cycle while in_ready_o is high. Scanning is a
//   single combinational pass from the scanner state registers into a
//   three-entry token queue. A token is registered into the queue on the
//   edge that accepts its byte and is offered once it reaches the head.
// in_ready_o is high while at most one token is queued. A byte that closes
//   one token and emits one of its own pushes two, which drops in_ready_o
//   until the receiver has taken enough to leave at most one queued.
// A stalled receiver fills the queue and then holds off input; nothing is
//   dropped. last_of_run_o marks the final token of each byte.
// After an EOF or error token the scanner halts: further bytes are still
//   accepted but produce nothing until reset.
// Reset (async, active low) empties the queue, sets line 1, column 0,
//   offset 0 and returns the scanner to idle. Depends on tlex_pkg and
//   tlex_scan.
module token_lexer import tlex_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        text_byte_i,
  input  logic              end_of_text_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [4:0]        token_kind_o,
  output logic [LINE_W-1:0] begin_line_o,
  output logic [COL_W-1:0]  begin_column_o,
  output logic [LINE_W-1:0] end_line_o,
  output logic [COL_W-1:0]  end_column_o,
  output logic [OFF_W-1:0]  start_offset_o,
  output logic [LEN_W-1:0]  token_length_o,
  output logic              last_of_run_o
);

  localparam int unsigned QDEPTH = 3;

  lex_state_t st_q, st_d, scan_st;
  tok_res_t   res0, res1;
  logic [1:0] res_cnt;
  tok_res_t   q_q [QDEPTH];
  tok_res_t   q_d [QDEPTH];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] base;
  logic       acc;
  logic       pop;

  tlex_scan u_scan (
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .st_i          (st_q),
    .st_o          (scan_st),
    .res0_o        (res0),
    .res1_o        (res1),
    .res_cnt_o     (res_cnt)
  );

  assign in_ready_o = (cnt_q <= 2'd1);
  assign acc        = in_valid_i && in_ready_o;
  assign pop        = out_valid_o && out_ready_i;
  assign st_d       = acc ? scan_st : st_q;

  always_comb begin
    base = cnt_q - {1'b0, pop};
    for (int i = 0; i < QDEPTH; i++) q_d[i] = q_q[i];
    if (pop) begin
      for (int i = 0; i < QDEPTH - 1; i++) q_d[i] = q_q[i+1];
    end
    if (acc) begin
      for (int i = 0; i < QDEPTH; i++) begin
        if (res_cnt != 2'd0 && base == 2'(i)) q_d[i] = res0;
        if (res_cnt == 2'd2 && base + 2'd1 == 2'(i)) q_d[i] = res1;
      end
    end
    cnt_d = base + (acc ? res_cnt : 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q         <= '0;
      st_q.mode     <= MODE_IDLE;
      st_q.cur_line <= LINE_W'(1);
      st_q.cur_col  <= '0;
      st_q.cur_off  <= '0;
      st_q.tok_line <= LINE_W'(1);
      st_q.tok_col  <= '0;
      st_q.tok_off  <= '0;
      st_q.tok_len  <= '0;
      st_q.head     <= '0;
    end else begin
      cnt_q <= cnt_d;
      st_q  <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDEPTH; i++) q_q[i] <= q_d[i];
  end

  assign out_valid_o    = (cnt_q != 2'd0);
  assign token_kind_o   = q_q[0].kind;
  assign begin_line_o   = q_q[0].bline;
  assign begin_column_o = q_q[0].bcol;
  assign end_line_o     = q_q[0].eline;
  assign end_column_o   = q_q[0].ecol;
  assign start_offset_o = q_q[0].off;
  assign token_length_o = q_q[0].len;
  assign last_of_run_o  = q_q[0].last;

endmodule

// ----- hdl/tlex_checker.sv -----
// Port-level checks on token_lexer, attached by the bind at the end.
// Depends on tlex_pkg and token_lexer_defines.svh.
`include "token_lexer_defines.svh"

module tlex_checker import tlex_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [4:0]        token_kind_o,
  input logic [OFF_W-1:0]  start_offset_o,
  input logic [LEN_W-1:0]  token_length_o,
  input logic              last_of_run_o
);

  `TLEX_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(token_kind_o) && $stable(start_offset_o), "stalled token changed")
  `TLEX_ASSERT(a_run_cont, out_valid_o && out_ready_i && !last_of_run_o |=> out_valid_o, "second token of a byte missing")
  `TLEX_ASSERT(a_end_last, out_valid_o && (token_kind_o == KIND_EOF || token_kind_o == KIND_ERROR) |-> last_of_run_o, "eof or error not last")
  `TLEX_ASSERT(a_len_nz, out_valid_o && token_kind_o != KIND_EOF && token_kind_o != KIND_ERROR |-> token_length_o != '0, "empty token")
  `TLEX_ASSERT_CR(a_halt, clk_i, rst_ni, out_valid_o && out_ready_i && (token_kind_o == KIND_EOF || token_kind_o == KIND_ERROR) |=> !out_valid_o, "token after halt")

endmodule

bind token_lexer tlex_checker u_tlex_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .token_kind_o   (token_kind_o),
  .start_offset_o (start_offset_o),
  .token_length_o (token_length_o),
  .last_of_run_o  (last_of_run_o)
);
